@@ rtl/idru_pkg.sv @@
// Package for the 64-bit divide/remainder unit: widths, operation codes and
// the types used by the front end, queue, divider pipeline and top level.
package idru_pkg;

  localparam int DataWidth = 64;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW = 1;

  typedef enum logic [1:0] {
    FUNC_UDIV = 2'd0,
    FUNC_UREM = 2'd1,
    FUNC_SDIV = 2'd2,
    FUNC_SREM = 2'd3
  } func_t;

  // Classified operation handed from the front end to the divider.
  typedef struct packed {
    logic [DataWidth-1:0] num;
    logic [DataWidth-1:0] den;
    logic                 want_rem;
    logic                 neg_res;
    logic                 div_zero;
  } op_t;

  // Per-stage state inside the divider pipeline.
  typedef struct packed {
    logic [DataWidth-1:0] part;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] num;
    logic [DataWidth-1:0] den;
    logic                 want_rem;
    logic                 neg_res;
    logic                 div_zero;
  } stage_t;

endpackage

@@ rtl/idru_front.sv @@
// Front end: registers an incoming transaction and classifies it into
// magnitudes, result sign and divide-by-zero. Depends on idru_pkg.
module idru_front import idru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [DataWidth-1:0] in_dividend,
  input  logic [DataWidth-1:0] in_divisor,
  output logic                 op_valid,
  input  logic                 op_ready,
  output op_t                  op_data
);

  logic valid_r;
  op_t  op_r;
  op_t  op_nxt;
  logic is_signed;
  logic neg_a;
  logic neg_b;

  assign in_ready = !valid_r || op_ready;

  // Classify the operation and take operand magnitudes.
  always_comb begin
    is_signed = (in_func == FUNC_SDIV) || (in_func == FUNC_SREM);
    neg_a = is_signed && in_dividend[DataWidth-1];
    neg_b = is_signed && in_divisor[DataWidth-1];
    op_nxt.num = neg_a ? (-in_dividend) : in_dividend;
    op_nxt.den = neg_b ? (-in_divisor) : in_divisor;
    op_nxt.want_rem = (in_func == FUNC_UREM) || (in_func == FUNC_SREM);
    op_nxt.neg_res = op_nxt.want_rem ? neg_a : (neg_a ^ neg_b);
    op_nxt.div_zero = (in_divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op_nxt;
    end
  end

  assign op_valid = valid_r;
  assign op_data  = op_r;

endmodule

@@ rtl/idru_queue.sv @@
// Two-entry queue between the front end and the divider pipeline.
// Depends on idru_pkg for the operation type.
module idru_queue import idru_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  op_t  wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output op_t  rd_data
);

  op_t                mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wptr_r;
  logic [QueuePtrW-1:0] rptr_r;
  logic [QueuePtrW:0]   count_r;
  logic do_wr;
  logic do_rd;

  assign wr_ready = (count_r != QueueDepth[QueuePtrW:0]);
  assign rd_valid = (count_r != '0);
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + 1'b1;
      if (do_rd) rptr_r <= rptr_r + 1'b1;
      if (do_wr && !do_rd) count_r <= count_r + (QueuePtrW+1)'(1);
      else if (do_rd && !do_wr) count_r <= count_r - (QueuePtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/idru_divider.sv @@
// Back end: one restoring-division step per pipeline stage, then sign fixup
// in an output register. Depends on idru_pkg.
module idru_divider import idru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  op_t                  op_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DataWidth-1:0] out_result,
  output logic                 out_divide_by_zero
);

  stage_t               st_r    [DataWidth];
  logic [DataWidth-1:0] vld_r;
  stage_t               st_nxt  [DataWidth];
  logic                 advance;
  logic                 out_vld_r;
  logic [DataWidth-1:0] res_r;
  logic                 dz_r;
  logic [DataWidth-1:0] res_nxt;
  stage_t               last;

  // The whole pipeline moves when the output register can take a value.
  assign advance  = !out_vld_r || out_ready;
  assign op_ready = advance;

  // One division step per stage; stage k handles dividend bit DataWidth-1-k.
  always_comb begin
    stage_t src;
    logic [DataWidth:0] sh;
    logic [DataWidth:0] diff;
    for (int k = 0; k < DataWidth; k++) begin
      if (k == 0) begin
        src.part = '0;
        src.quo = '0;
        src.num = op_data.num;
        src.den = op_data.den;
        src.want_rem = op_data.want_rem;
        src.neg_res = op_data.neg_res;
        src.div_zero = op_data.div_zero;
      end else begin
        src = st_r[k-1];
      end
      sh = {src.part, src.num[DataWidth-1]};
      diff = sh - {1'b0, src.den};
      st_nxt[k] = src;
      st_nxt[k].num = {src.num[DataWidth-2:0], 1'b0};
      if (!diff[DataWidth]) begin
        st_nxt[k].part = diff[DataWidth-1:0];
        st_nxt[k].quo = {src.quo[DataWidth-2:0], 1'b1};
      end else begin
        st_nxt[k].part = sh[DataWidth-1:0];
        st_nxt[k].quo = {src.quo[DataWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[DataWidth-2:0], op_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < DataWidth; k++) st_r[k] <= st_nxt[k];
    end
  end

  // Select quotient or remainder, apply the sign, zero on divide by zero.
  always_comb begin
    last = st_r[DataWidth-1];
    res_nxt = last.want_rem ? last.part : last.quo;
    if (last.neg_res) res_nxt = -res_nxt;
    if (last.div_zero) res_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= vld_r[DataWidth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
      dz_r  <= last.div_zero;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_result         = res_r;
  assign out_divide_by_zero = dz_r;

endmodule

@@ rtl/int64_divide_remainder_unit_core.sv @@
// 64-bit divide/remainder unit: front end, two-entry queue, 64-stage divider.
// Accepts one transaction per cycle unless the result output stalls, with one
// restoring step per divider stage. Synchronous active-low reset
// clears all valid bits; payload registers are not reset.
// Depends on idru_pkg, idru_front, idru_queue and idru_divider.
module int64_divide_remainder_unit_core import idru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [DataWidth-1:0] in_dividend,
  input  logic [DataWidth-1:0] in_divisor,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DataWidth-1:0] out_result,
  output logic                 out_divide_by_zero
);

  logic f_valid;
  logic f_ready;
  op_t  f_data;
  logic q_valid;
  logic q_ready;
  op_t  q_data;

  idru_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_dividend, .in_divisor,
    .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
  );

  idru_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  idru_divider u_div (
    .clk, .rst_n,
    .op_valid(q_valid), .op_ready(q_ready), .op_data(q_data),
    .out_valid, .out_ready, .out_result, .out_divide_by_zero
  );

  // A divide-by-zero result always carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result == '0)
    else $error("divide by zero with nonzero result");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

  // A front-end transaction blocked by a full queue holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |=> f_valid && $stable(f_data))
    else $error("blocked front-end transaction changed");

endmodule

@@ bench/int64_divide_remainder_unit_core_test.sv @@
// Self-checking bench for the 64-bit divide/remainder unit core.
// A directed table, then random division transactions, each result checked
// against an in-bench restoring-division predictor. Depends on idru_pkg.
module int64_divide_remainder_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import idru_pkg::*;

  localparam int MaxCycles = 2000000;
  localparam int Latency = 66;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] quot_rem;
    logic        zero_div;
  } div_result_t;

  typedef struct {
    func_t       op;
    logic [63:0] num;
    logic [63:0] den;
    logic        known;
    logic [63:0] want;
  } div_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = FUNC_UDIV;
  logic [63:0] in_dividend = '0;
  logic [63:0] in_divisor = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_result;
  logic out_divide_by_zero;

  div_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int hold_left = 0;

  int64_divide_remainder_unit_core dut (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Restoring division over 64 steps, with sign handling for signed codes.
  function automatic div_result_t predict_division(func_t op, logic [63:0] a,
                                                   logic [63:0] b);
    div_result_t r;
    logic [63:0] part, q, res;
    logic carry, neg_a, neg_b, is_signed;
    part = '0;
    q = '0;
    is_signed = op[1];
    neg_a = is_signed & a[63];
    neg_b = is_signed & b[63];
    if (b == '0) begin
      r.quot_rem = '0;
      r.zero_div = 1'b1;
      return r;
    end
    if (neg_a) a = -a;
    if (neg_b) b = -b;
    for (int s = 63; s >= 0; s--) begin
      carry = part[63];
      part = {part[62:0], a[s]};
      if (carry || part >= b) begin
        part = part - b;
        q[s] = 1'b1;
      end
    end
    if (op[0]) res = neg_a ? -part : part;
    else res = (neg_a != neg_b) ? -q : q;
    r.quot_rem = res;
    r.zero_div = 1'b0;
    return r;
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off counted here.
  always @(negedge clk) begin
    if (hold_recv && hold_left == 0) hold_left = 300;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_recv = 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk) begin
    div_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %h", out_result);
      end else begin
        e = pending_results.pop_front();
        if (e.quot_rem !== out_result || e.zero_div !== out_divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h/%b got %h/%b", e.quot_rem, e.zero_div,
                     out_result, out_divide_by_zero);
        end
      end
    end
  end

  // Drive one transaction and hold it until accepted; valid stays high so the
  // next transaction can follow without a gap.
  task automatic send_division(func_t op, logic [63:0] a, logic [63:0] b,
                               logic known, logic [63:0] want);
    div_result_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_dividend <= a;
    in_divisor <= b;
    e = predict_division(op, a, b);
    if (known && e.quot_rem !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("Table row %h: predictor gives %h", want, e.quot_rem);
    end
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(e);
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_operand();
    case ($urandom_range(5))
      0: return {32'h0, $urandom()};
      1: return {$urandom(), $urandom()};
      2: return 64'($urandom_range(9));
      3: return -64'($urandom_range(9));
      4: return {$urandom(), $urandom()} >> $urandom_range(63);
      default: return {$urandom_range(1) ? MinNeg : 64'h0} ^ 64'($urandom_range(3));
    endcase
  endfunction

  div_row_t table_rows[$];

  initial begin
    table_rows = '{
      '{FUNC_UDIV, 64'd100, 64'd7, 1'b1, 64'd14},
      '{FUNC_UREM, 64'd100, 64'd7, 1'b1, 64'd2},
      '{FUNC_SDIV, -64'd100, 64'd7, 1'b1, -64'd14},
      '{FUNC_SREM, -64'd100, 64'd7, 1'b1, -64'd2},
      '{FUNC_SDIV, 64'd100, -64'd7, 1'b1, -64'd14},
      '{FUNC_SREM, 64'd100, -64'd7, 1'b1, 64'd2},
      '{FUNC_UDIV, 64'd5, 64'd0, 1'b1, 64'd0},
      '{FUNC_UREM, 64'd5, 64'd0, 1'b1, 64'd0},
      '{FUNC_SDIV, MinNeg, 64'd0, 1'b1, 64'd0},
      '{FUNC_SREM, AllOnes, 64'd0, 1'b1, 64'd0},
      // Most negative over minus one wraps.
      '{FUNC_SDIV, MinNeg, AllOnes, 1'b1, MinNeg},
      '{FUNC_SREM, MinNeg, AllOnes, 1'b1, 64'd0},
      '{FUNC_UDIV, AllOnes, 64'd1, 1'b1, AllOnes},
      '{FUNC_UDIV, AllOnes, AllOnes, 1'b1, 64'd1},
      '{FUNC_UREM, AllOnes, MinNeg, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
      '{FUNC_UDIV, 64'd0, AllOnes, 1'b1, 64'd0},
      '{FUNC_SDIV, AllOnes, AllOnes, 1'b1, 64'd1},
      '{FUNC_UDIV, MinNeg, 64'd3, 1'b0, 64'd0},
      '{FUNC_SDIV, MinNeg, 64'd3, 1'b0, 64'd0},
      '{FUNC_SREM, MinNeg, 64'd3, 1'b0, 64'd0},
      '{FUNC_UREM, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9, 1'b0, 64'd0}
    };
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (table_rows[i])
      send_division(table_rows[i].op, table_rows[i].num, table_rows[i].den,
                    table_rows[i].known, table_rows[i].want);

    // Random phases with different idling mixes.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; hold_recv = 1'b1; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 140; n++)
        send_division(func_t'($urandom_range(3)), random_operand(),
                      ($urandom_range(19) == 0) ? 64'd0 : random_operand(), 1'b0, '0);
      // After phase 1, the sender pauses until every result has drained.
      if (phase == 1) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
rtl/idru_pkg.sv
rtl/idru_front.sv
rtl/idru_queue.sv
rtl/idru_divider.sv
rtl/int64_divide_remainder_unit_core.sv
bench/int64_divide_remainder_unit_core_test.sv
